### design/bdq_pkg.sv
// Shared types and constants for the bounded array deque unit.
// Used by bounded_array_deque_unit and its testbench; depends on nothing else.
package bdq_pkg;

   // Operation codes carried in the request word.
   localparam logic [2:0] OP_PUSH_BACK  = 3'd0;
   localparam logic [2:0] OP_PUSH_FRONT = 3'd1;
   localparam logic [2:0] OP_POP_BACK   = 3'd2;
   localparam logic [2:0] OP_POP_FRONT  = 3'd3;
   localparam logic [2:0] OP_READ_FRONT = 3'd4;
   localparam logic [2:0] OP_READ_BACK  = 3'd5;

   // Capacity register reset value and lower limit.
   localparam logic [4:0] CAP_RESET = 5'd16;
   localparam int         CAP_MIN   = 2;

   // Status codes returned with every result word.
   typedef enum logic [2:0] {
      ST_OK        = 3'd0,
      ST_FULL      = 3'd1,
      ST_REAR_END  = 3'd2,
      ST_FRONT_END = 3'd3,
      ST_EMPTY     = 3'd4
   } status_type;

   // Control sequencer states.
   typedef enum logic [1:0] {
      S_IDLE,
      S_READ,
      S_LOAD,
      S_REDUCE
   } state_type;

   typedef struct packed {
      logic        [2:0]  operation;
      logic signed [31:0] push_value;
   } req_type;

   typedef struct packed {
      logic signed [31:0] read_value;
      status_type         status;
      logic               is_empty;
      logic               is_full;
   } rsp_type;

endpackage

### design/bdq_ram.sv
// Generic single-write, single-read synchronous RAM with a registered read port.
// Stand-alone; no package needed.
module bdq_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port and registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### design/bounded_array_deque_unit.sv
// Bounded array deque unit: indices and control around one element RAM.
// Depends on bdq_pkg and bdq_ram.
//
// Usage: each request word on req_* carries an operation (push back, push
// front, pop back, pop front, read front, read back) and a push value. Each
// accepted word produces exactly one response word on rsp_*: the value popped
// or read, a status code and the empty and full flags after the operation.
// Pushes and refused operations answer in the cycle after acceptance; pops and
// reads that succeed answer from state S_READ, after the registered read of the
// element RAM. One word is in work at a time, so a push may be accepted every
// cycle while each response is taken, and a pop or read holds the next word off.
// A response waiting in the output register does not block acceptance as long
// as rsp_ready takes it at the same edge; a stalled receiver holds the response
// and req_ready stays low until it is taken.
// The capacity register is written through csr_wr_en/csr_wr_data; the user must
// write it only while idle, which the unit does not enforce. After each write
// it rebuilds its fill residue modulo capacity, one subtraction per cycle, with
// req_ready low. Synchronous reset empties the deque and sets capacity to 16;
// the RAM contents are not cleared, and no entry is ever read before it is written.
module bounded_array_deque_unit #(
   parameter int DEPTH      = 16,
   parameter int DATA_WIDTH = 32
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  bdq_pkg::req_type req_word,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output bdq_pkg::rsp_type rsp_word,
   input  logic             csr_wr_en,
   input  logic [4:0]       csr_wr_data
);
   import bdq_pkg::*;

   localparam int IW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);
   localparam int EW = (CW > 5) ? CW : 5;

   state_type        state_ff, state_in;
   logic             pending_ff, pending_in;
   logic [4:0]       capacity_ff;
   logic [IW-1:0]    front_ff, front_in;
   logic [IW-1:0]    rear_ff, rear_in;
   logic             empty_ff, empty_in;
   logic [EW-1:0]    resid_ff, resid_in;
   logic             rsp_valid_ff, rsp_valid_in;
   rsp_type          rsp_ff, rsp_in;

   logic [EW-1:0]    cap_ext, eff_cap;
   logic [EW-1:0]    resid_inc, resid_dec;
   logic [EW-1:0]    fill_count;
   logic             accept, full_now;
   logic             wr_en, rd_en;
   logic [IW-1:0]    wr_addr, rd_addr;
   logic [DATA_WIDTH-1:0] wr_data, rd_data;
   status_type       status;

   // Effective capacity, clamped to the range of the store.
   assign cap_ext = EW'(capacity_ff);
   always_comb begin
      if (cap_ext < EW'(CAP_MIN)) begin
         eff_cap = EW'(CAP_MIN);
      end else if (cap_ext > EW'(DEPTH)) begin
         eff_cap = EW'(DEPTH);
      end else begin
         eff_cap = cap_ext;
      end
   end

   // The residue holds the element count modulo capacity; full means the deque is
   // not empty, the residue is zero and the front slot lies below capacity.
   assign resid_inc  = (resid_ff + EW'(1) == eff_cap) ? '0 : resid_ff + EW'(1);
   assign resid_dec  = (resid_ff == '0) ? eff_cap - EW'(1) : resid_ff - EW'(1);
   assign full_now   = !empty_ff && (resid_ff == '0) && (EW'(front_ff) < eff_cap);
   assign fill_count = EW'(rear_ff) - EW'(front_ff) + EW'(1);

   assign req_ready = (state_ff == S_IDLE) && !pending_ff && (!rsp_valid_ff || rsp_ready);
   assign accept    = req_valid && req_ready;
   assign wr_data   = DATA_WIDTH'(req_word.push_value);

   // Sequencer: operation decode, index update and residue rebuild.
   always_comb begin
      state_in     = state_ff;
      pending_in   = pending_ff;
      front_in     = front_ff;
      rear_in      = rear_ff;
      empty_in     = empty_ff;
      resid_in     = resid_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;
      status       = ST_OK;
      wr_en        = 1'b0;
      wr_addr      = '0;
      rd_en        = 1'b0;
      rd_addr      = '0;

      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         S_IDLE: begin
            if (pending_ff) begin
               pending_in = 1'b0;
               state_in   = S_LOAD;
            end else if (accept) begin
               case (req_word.operation)
                  OP_PUSH_BACK: begin
                     if (full_now) begin
                        status = ST_FULL;
                     end else if (empty_ff) begin
                        front_in = '0;
                        rear_in  = '0;
                        empty_in = 1'b0;
                        resid_in = EW'(1);
                        wr_en    = 1'b1;
                        wr_addr  = '0;
                     end else if (EW'(rear_ff) + EW'(1) >= eff_cap) begin
                        status = ST_REAR_END;
                     end else begin
                        rear_in  = rear_ff + IW'(1);
                        resid_in = resid_inc;
                        wr_en    = 1'b1;
                        wr_addr  = rear_ff + IW'(1);
                     end
                  end
                  OP_PUSH_FRONT: begin
                     if (empty_ff) begin
                        front_in = '0;
                        rear_in  = '0;
                        empty_in = 1'b0;
                        resid_in = EW'(1);
                        wr_en    = 1'b1;
                        wr_addr  = '0;
                     end else if (front_ff == '0) begin
                        status = ST_FRONT_END;
                     end else begin
                        front_in = front_ff - IW'(1);
                        resid_in = resid_inc;
                        wr_en    = 1'b1;
                        wr_addr  = front_ff - IW'(1);
                     end
                  end
                  OP_POP_BACK, OP_POP_FRONT: begin
                     if (empty_ff) begin
                        status = ST_EMPTY;
                     end else begin
                        rd_en   = 1'b1;
                        rd_addr = (req_word.operation == OP_POP_BACK) ? rear_ff : front_ff;
                        if (front_ff == rear_ff) begin
                           front_in = '0;
                           rear_in  = '0;
                           empty_in = 1'b1;
                           resid_in = '0;
                        end else if (req_word.operation == OP_POP_BACK) begin
                           rear_in  = rear_ff - IW'(1);
                           resid_in = resid_dec;
                        end else begin
                           front_in = front_ff + IW'(1);
                           resid_in = resid_dec;
                        end
                     end
                  end
                  OP_READ_FRONT, OP_READ_BACK: begin
                     if (empty_ff) begin
                        status = ST_EMPTY;
                     end else begin
                        rd_en   = 1'b1;
                        rd_addr = (req_word.operation == OP_READ_FRONT) ? front_ff : rear_ff;
                     end
                  end
                  default: begin
                     status = ST_OK;
                  end
               endcase

               // Flags reflect the state after the operation.
               rsp_in.read_value = '0;
               rsp_in.status     = status;
               rsp_in.is_empty   = empty_in;
               rsp_in.is_full    = !empty_in && (resid_in == '0) &&
                                   (EW'(front_in) < eff_cap);
               if (rd_en) begin
                  rsp_valid_in = 1'b0;
                  state_in     = S_READ;
               end else begin
                  rsp_valid_in = 1'b1;
               end
            end
         end
         S_READ: begin
            // The element read last cycle is now on the RAM output.
            rsp_in.read_value = 32'(signed'(rd_data));
            rsp_valid_in      = 1'b1;
            state_in          = S_IDLE;
         end
         S_LOAD: begin
            resid_in = empty_ff ? '0 : fill_count;
            state_in = S_REDUCE;
         end
         S_REDUCE: begin
            if (pending_ff) begin
               pending_in = 1'b0;
               state_in   = S_LOAD;
            end else if (resid_ff >= eff_cap) begin
               resid_in = resid_ff - eff_cap;
            end else begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      // A capacity write always schedules a residue rebuild.
      if (csr_wr_en) begin
         pending_in = 1'b1;
      end
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         pending_ff   <= 1'b0;
         capacity_ff  <= CAP_RESET;
         front_ff     <= '0;
         rear_ff      <= '0;
         empty_ff     <= 1'b1;
         resid_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         pending_ff   <= pending_in;
         front_ff     <= front_in;
         rear_ff      <= rear_in;
         empty_ff     <= empty_in;
         resid_ff     <= resid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_wr_en) begin
            capacity_ff <= csr_wr_data;
         end
      end
   end

   // Response payload register.
   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   // Element store.
   bdq_ram #(
      .WIDTH (DATA_WIDTH),
      .DEPTH (DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_ff;

   // An empty deque always has both indices parked at slot zero.
   a_empty_parked : assert property (@(posedge clock) disable iff (reset)
      empty_ff |-> (front_ff == '0) && (rear_ff == '0))
      else $error("empty deque with indices away from zero");

   // The occupied run never inverts.
   a_run_order : assert property (@(posedge clock) disable iff (reset)
      !empty_ff |-> (front_ff <= rear_ff))
      else $error("front index above rear index");

   // Once rebuilt, the residue stays below capacity.
   a_resid_range : assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_IDLE) && !pending_ff |-> (resid_ff < eff_cap))
      else $error("fill residue out of range");

   // No request is taken and no response is offered while a RAM read is outstanding.
   a_read_interlock : assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_READ) |-> !req_ready && !rsp_valid_ff)
      else $error("request accepted during outstanding read");

endmodule

### tb/bounded_array_deque_unit_tb.sv
// Self-checking testbench for bounded_array_deque_unit: directed and random words
// checked against a cycle-free model of the deque. Depends on bdq_pkg and the unit.
`timescale 1ns / 100ps

module bounded_array_deque_unit_tb;
   import bdq_pkg::*;

   localparam int DEPTH          = 16;
   localparam int WATCHDOG_LIMIT = 4000;
   localparam int HOLD_CYCLES    = 300;
   localparam int ANSWER_SLOTS   = 4096;

   // Codes 6 and 7 are not assigned to any operation; the unit leaves the deque unchanged and answers OK.
   localparam logic [2:0] OP_SPARE_LO = 3'd6;
   localparam logic [2:0] OP_SPARE_HI = 3'd7;

   localparam logic [31:0] MOST_NEGATIVE = 32'h8000_0000;
   localparam logic [31:0] MOST_POSITIVE = 32'h7fff_ffff;

   logic       clock       = 1'b0;
   logic       reset       = 1'b1;
   logic       req_valid   = 1'b0;
   logic       req_ready;
   req_type    req_word    = '0;
   logic       rsp_valid;
   logic       rsp_ready   = 1'b0;
   rsp_type    rsp_word;
   logic       csr_wr_en   = 1'b0;
   logic [4:0] csr_wr_data = '0;

   // Model state of the deque and its capacity register.
   logic [3:0]         head_slot   = '0;
   logic [3:0]         tail_slot   = '0;
   logic               deque_empty = 1'b1;
   logic [4:0]         cap_setting = CAP_RESET;
   logic signed [31:0] slot_data [DEPTH];

   // Expected response words in order, kept in a ring with two counters.
   rsp_type answer_ring [ANSWER_SLOTS];
   int      answer_wr      = 0;
   int      answer_rd      = 0;
   int      mismatch_count = 0;
   int      send_idle_pct  = 0;
   int      recv_stall_pct = 0;
   int      hold_stamp     = 0;
   int      hold_seen      = 0;
   int      hold_left      = 0;
   int      quiet_cycles   = 0;

   bounded_array_deque_unit dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_word    (req_word),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_word    (rsp_word),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   always #4 clock = ~clock;

   // Number of response words predicted but not yet taken.
   function automatic int answers_owed();
      return answer_wr - answer_rd;
   endfunction

   // Capacity as the unit applies it: clamped into 2..DEPTH.
   function automatic int used_capacity();
      if (cap_setting < CAP_MIN) return CAP_MIN;
      if (cap_setting > DEPTH) return DEPTH;
      return int'(cap_setting);
   endfunction

   // Wrap-style full test on the current model state.
   function automatic logic wrap_full();
      if (deque_empty) return 1'b0;
      return ((int'(tail_slot) + 1) % used_capacity()) == int'(head_slot);
   endfunction

   // Apply one operation to the model and return the response word it produces.
   function automatic rsp_type compute_deque_answer(req_type w);
      rsp_type r;
      r.read_value = '0;
      r.status     = ST_OK;
      case (w.operation)
         OP_PUSH_BACK: begin
            if (wrap_full()) begin
               r.status = ST_FULL;
            end else if (deque_empty) begin
               head_slot    = '0;
               tail_slot    = '0;
               deque_empty  = 1'b0;
               slot_data[0] = w.push_value;
            end else if (int'(tail_slot) + 1 >= used_capacity()) begin
               r.status = ST_REAR_END;
            end else begin
               tail_slot            = tail_slot + 1'b1;
               slot_data[tail_slot] = w.push_value;
            end
         end
         OP_PUSH_FRONT: begin
            if (deque_empty) begin
               head_slot    = '0;
               tail_slot    = '0;
               deque_empty  = 1'b0;
               slot_data[0] = w.push_value;
            end else if (head_slot == 0) begin
               r.status = ST_FRONT_END;
            end else begin
               head_slot            = head_slot - 1'b1;
               slot_data[head_slot] = w.push_value;
            end
         end
         OP_POP_BACK, OP_POP_FRONT: begin
            if (deque_empty) begin
               r.status = ST_EMPTY;
            end else begin
               r.read_value = (w.operation == OP_POP_BACK) ? slot_data[tail_slot]
                                                           : slot_data[head_slot];
               if (head_slot == tail_slot) begin
                  head_slot   = '0;
                  tail_slot   = '0;
                  deque_empty = 1'b1;
               end else if (w.operation == OP_POP_BACK) begin
                  tail_slot = tail_slot - 1'b1;
               end else begin
                  head_slot = head_slot + 1'b1;
               end
            end
         end
         OP_READ_FRONT, OP_READ_BACK: begin
            if (deque_empty) r.status = ST_EMPTY;
            else r.read_value = (w.operation == OP_READ_FRONT) ? slot_data[head_slot]
                                                               : slot_data[tail_slot];
         end
         default: ;
      endcase
      r.is_empty = deque_empty;
      r.is_full  = wrap_full();
      return r;
   endfunction

   // Check each taken response first, then record the answer for each taken request.
   always @(posedge clock) begin : answer_check
      rsp_type want;
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            if (answers_owed() == 0) begin
               if (mismatch_count < 10) $display("unexpected response word %h", rsp_word);
               mismatch_count++;
            end else begin
               want = answer_ring[answer_rd % ANSWER_SLOTS];
               answer_rd++;
               if (rsp_word.read_value !== want.read_value || rsp_word.status !== want.status
                   || rsp_word.is_empty !== want.is_empty
                   || rsp_word.is_full !== want.is_full) begin
                  if (mismatch_count < 10)
                     $display("mismatch at %0t: expected %h/%0d/%b/%b, got %h/%0d/%b/%b",
                              $realtime, want.read_value, want.status, want.is_empty,
                              want.is_full, rsp_word.read_value, rsp_word.status,
                              rsp_word.is_empty, rsp_word.is_full);
                  mismatch_count++;
               end
            end
         end
         if (req_valid && req_ready) begin
            answer_ring[answer_wr % ANSWER_SLOTS] = compute_deque_answer(req_word);
            answer_wr++;
         end
      end
   end

   // Receiver: random stalls, plus one long hold-off whenever hold_stamp moves.
   always @(posedge clock) begin
      if (hold_seen != hold_stamp) begin
         hold_seen <= hold_stamp;
         hold_left <= HOLD_CYCLES;
         rsp_ready <= 1'b0;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   // Watchdog on cycles in which no word moves on either channel.
   always @(posedge clock) begin
      if (reset || csr_wr_en || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("bounded_array_deque_unit_tb failed");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // Offer one request word, with random idle cycles ahead of it.
   task automatic send_word(input logic [2:0] op, input logic [31:0] value);
      req_type w;
      w.operation  = op;
      w.push_value = value;
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_word  <= w;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
   endtask

   // Stop offering and wait until every expected response has been taken.
   task automatic drain_responses();
      req_valid <= 1'b0;
      @(posedge clock);
      while (answers_owed() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_capacity(input logic [4:0] value);
      drain_responses();
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      cap_setting = value;
      @(posedge clock);
      csr_wr_en <= 1'b0;
   endtask

   task automatic set_idling(input int send_pct, input int recv_pct);
      send_idle_pct  = send_pct;
      recv_stall_pct = recv_pct;
   endtask

   function automatic logic [31:0] pick_value();
      case ($urandom_range(7))
         0: return MOST_NEGATIVE;
         1: return MOST_POSITIVE;
         2: return '0;
         3: return '1;
         default: return $urandom;
      endcase
   endfunction

   // Operation mix; push_pct tilts the deque toward filling or draining.
   function automatic logic [2:0] pick_operation(input int push_pct);
      int roll;
      int rest;
      roll = $urandom_range(99);
      rest = 96 - push_pct;
      if (roll < 4) return $urandom_range(1) ? OP_SPARE_HI : OP_SPARE_LO;
      roll -= 4;
      if (roll < push_pct * 2 / 3) return OP_PUSH_BACK;
      if (roll < push_pct) return OP_PUSH_FRONT;
      roll -= push_pct;
      if (roll < rest * 3 / 10) return OP_POP_BACK;
      if (roll < rest * 7 / 10) return OP_POP_FRONT;
      if (roll < rest * 85 / 100) return OP_READ_FRONT;
      return OP_READ_BACK;
   endfunction

   task automatic random_burst(input int count, input int push_pct);
      repeat (count) send_word(pick_operation(push_pct), pick_value());
   endtask

   // Pops, reads and unused codes on the deque as it comes out of reset.
   task automatic test_empty_deque();
      send_word(OP_READ_FRONT, '0);
      send_word(OP_POP_BACK, '1);
      send_word(OP_POP_FRONT, MOST_NEGATIVE);
      send_word(OP_READ_BACK, MOST_POSITIVE);
      send_word(OP_SPARE_LO, 32'h1234_5678);
      send_word(OP_SPARE_HI, '1);
   endtask

   // Walk a capacity-4 deque through full, rear end, front end and back to empty.
   task automatic test_boundaries();
      write_capacity(5'd4);
      send_word(OP_PUSH_FRONT, MOST_POSITIVE);
      send_word(OP_PUSH_BACK, MOST_NEGATIVE);
      send_word(OP_PUSH_BACK, '1);
      send_word(OP_PUSH_BACK, '0);
      send_word(OP_PUSH_BACK, 32'd5);
      send_word(OP_PUSH_FRONT, 32'd6);
      send_word(OP_READ_FRONT, '0);
      send_word(OP_READ_BACK, '0);
      send_word(OP_POP_FRONT, '0);
      send_word(OP_PUSH_BACK, 32'h5a5a_5a5a);
      send_word(OP_PUSH_FRONT, 32'ha5a5_a5a5);
      repeat (4) send_word(OP_POP_BACK, '0);
      send_word(OP_POP_BACK, '0);
      send_word(OP_POP_FRONT, '0);
   endtask

   // Capacity values at and beyond both ends of the legal range.
   task automatic test_capacity_settings();
      logic [4:0] settings [8];
      settings = '{5'd0, 5'd1, 5'd2, 5'd3, 5'd16, 5'd17, 5'd31, 5'd8};
      foreach (settings[i]) begin
         write_capacity(settings[i]);
         random_burst(30, 70);
         random_burst(20, 30);
      end
   endtask

   // Shrink the capacity while the deque still holds a long run of elements.
   task automatic test_shrink_under_contents();
      write_capacity(5'd16);
      repeat (16) send_word(OP_POP_BACK, '0);
      repeat (12) send_word(OP_PUSH_BACK, pick_value());
      write_capacity(5'd3);
      random_burst(40, 35);
   endtask

   // Receiver holds off for a long stretch while requests keep coming.
   task automatic test_backpressure();
      set_idling(0, 0);
      write_capacity(5'd16);
      hold_stamp++;
      random_burst(40, 60);
      drain_responses();
   endtask

   // Long random run through the four idling phases and assorted capacities.
   task automatic test_random_phases();
      int send_pcts [4];
      int recv_pcts [4];
      send_pcts = '{0, 65, 0, 6};
      recv_pcts = '{0, 0, 65, 6};
      for (int p = 0; p < 4; p++) begin
         set_idling(send_pcts[p], recv_pcts[p]);
         repeat (3) begin
            if ($urandom_range(9) == 0) write_capacity(5'($urandom_range(31)));
            else write_capacity(5'($urandom_range(16, 2)));
            repeat (2) begin
               random_burst(25, 65);
               random_burst(25, 35);
            end
         end
      end
   endtask

   initial begin
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      set_idling(0, 0);
      test_empty_deque();
      test_boundaries();
      test_capacity_settings();
      test_shrink_under_contents();
      test_backpressure();
      test_random_phases();
      drain_responses();
      repeat (8) @(posedge clock);
      if (mismatch_count == 0 && answers_owed() == 0) begin
         $display("bounded_array_deque_unit_tb passed");
      end else begin
         $display("bounded_array_deque_unit_tb failed");
      end
      $finish;
   end

endmodule

### files.f
design/bdq_pkg.sv
design/bdq_ram.sv
design/bounded_array_deque_unit.sv
tb/bounded_array_deque_unit_tb.sv
